/* hw/rtl/sptq_pkg.sv */
// ----------------------------------------------------------------------------
// sptq_pkg: shared types and codes for the sorted priority task queue
// Command and status codes, the stored entry and the result record.
// ----------------------------------------------------------------------------
package sptq_pkg;

   localparam int IdWidth  = 16;
   localparam int PriWidth = 8;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_POP    = 2'd2,
      KIND_VIEW   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [IdWidth-1:0]  id;
      logic [PriWidth-1:0] pri;
   } entry_type;

   typedef struct packed {
      status_type          status;
      logic [IdWidth-1:0]  id;
      logic [PriWidth-1:0] pri;
      logic                last;
   } rsp_type;

endpackage

/* hw/rtl/sptq_mem.sv */
// ----------------------------------------------------------------------------
// sptq_mem: entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sptq_mem #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  sptq_pkg::entry_type       wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output sptq_pkg::entry_type       rd_data
);
   import sptq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sptq_rsp_reg.sv */
// ----------------------------------------------------------------------------
// sptq_rsp_reg: result output register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module sptq_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sptq_pkg::rsp_type load_rsp,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sptq_pkg::rsp_type rsp
);
   import sptq_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

/* hw/rtl/sorted_priority_task_queue.sv */
// Insert walks the list from the tail, delete, pop and view from the head; full
//   and empty answers are loaded into the result register when accepted.
// Throughput: one command at a time; the read port walks one entry per cycle, but
//   view pauses while results are held; entries shift through the write port.
// Reset: clears the entry count and the sequencer; entry storage is not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_task_queue: sorted list priority queue
// Entries live in a memory in ascending priority order; insert, delete and pop
// walk the list with a read-modify-write pass that shifts entries; view only reads.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [sptq_pkg::IdWidth-1:0]  req_task_id,
   input  logic [sptq_pkg::PriWidth-1:0] req_priority_req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [sptq_pkg::IdWidth-1:0]  rsp_out_id,
   output logic [sptq_pkg::PriWidth-1:0] rsp_out_priority,
   output logic                          rsp_last
);
   import sptq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_INSERT   = 4'b0010,
      ST_INS_HEAD = 4'b0100,
      ST_SCAN     = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   entry_type           hit_ff, hit_in;
   kind_type            kind_ff;
   logic [IdWidth-1:0]  id_ff;
   logic [PriWidth-1:0] pri_ff;

   logic                accept;
   logic                out_ready;
   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   entry_type           wr_data, rd_data, new_entry;
   logic                emit_en;
   rsp_type             emit_rsp, rsp;
   logic                last_entry;
   logic                match;

   assign req_stall = !((state_ff == ST_IDLE) && out_ready);
   assign accept    = req_valid && !req_stall;
   assign new_entry = '{id: id_ff, pri: pri_ff};
   assign last_entry = (CW'(idx_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = new_entry;
      emit_en  = 1'b0;
      emit_rsp = '{status: STATUS_OK, id: '0, pri: '0, last: 1'b1};
      match    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == KIND_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     emit_en         = 1'b1;
                     emit_rsp.status = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{id: req_task_id, pri: req_priority_req};
                     emit_en  = 1'b1;
                     emit_rsp = '{status: STATUS_OK, id: req_task_id,
                                  pri: req_priority_req, last: 1'b1};
                     count_in = count_ff + CW'(1);
                  end else begin
                     // walk from the tail toward the head
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     idx_in   = AW'(count_ff - CW'(1));
                     state_in = ST_INSERT;
                  end
               end else begin
                  if (count_ff == '0) begin
                     emit_en         = 1'b1;
                     emit_rsp.status = STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if (rd_data.pri > pri_ff) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_INS_HEAD;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end else begin
               wr_data  = new_entry;
               emit_en  = 1'b1;
               emit_rsp = '{status: STATUS_OK, id: id_ff, pri: pri_ff, last: 1'b1};
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_INS_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_entry;
            emit_en  = 1'b1;
            emit_rsp = '{status: STATUS_OK, id: id_ff, pri: pri_ff, last: 1'b1};
            count_in = count_ff + CW'(1);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (kind_ff == KIND_VIEW) begin
               rd_en = 1'b1;
               if (out_ready) begin
                  emit_en  = 1'b1;
                  emit_rsp = '{status: STATUS_OK, id: rd_data.id, pri: rd_data.pri,
                               last: last_entry};
                  if (last_entry) begin
                     rd_en    = 1'b0;
                     state_in = ST_IDLE;
                  end else begin
                     rd_addr = idx_ff + AW'(1);
                     idx_in  = idx_ff + AW'(1);
                  end
               end else begin
                  // result slot busy: fetch the same entry again
                  rd_addr = idx_ff;
               end
            end else begin
               if (kind_ff == KIND_POP) begin
                  match = !found_ff && (idx_ff == '0);
               end else begin
                  match = !found_ff && (rd_data.id == id_ff);
               end
               if (found_ff) begin
                  // close the gap left by the removed entry
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - AW'(1);
                  wr_data = rd_data;
               end
               if (match) begin
                  found_in = 1'b1;
                  hit_in   = rd_data;
               end
               if (last_entry) begin
                  emit_en  = 1'b1;
                  state_in = ST_IDLE;
                  if (found_ff) begin
                     emit_rsp = '{status: STATUS_OK, id: hit_ff.id, pri: hit_ff.pri,
                                  last: 1'b1};
                     count_in = count_ff - CW'(1);
                  end else if (match) begin
                     emit_rsp = '{status: STATUS_OK, id: rd_data.id, pri: rd_data.pri,
                                  last: 1'b1};
                     count_in = count_ff - CW'(1);
                  end else begin
                     emit_rsp.status = STATUS_NOTFOUND;
                  end
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         id_ff   <= req_task_id;
         pri_ff  <= req_priority_req;
      end
   end

   sptq_mem #(
      .DEPTH(CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sptq_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit_en),
      .load_rsp  (emit_rsp),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status       = rsp.status;
   assign rsp_out_id       = rsp.id;
   assign rsp_out_priority = rsp.pri;
   assign rsp_last         = rsp.last;

   // entry count never runs past the memory depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a result is only produced when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      emit_en |-> out_ready)
      else $error("result produced while output register busy");

   // shifting passes never read and write the same entry in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("memory read and write to the same entry");

   // insert into a full queue answers with full on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_INSERT) && (count_ff == CW'(CAPACITY)))
      |=> (rsp_valid && (rsp_status == STATUS_FULL) && $stable(count_ff)))
      else $error("insert on full queue not rejected");

endmodule

/* bench/sptq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptq_checker: result checker for the sorted priority task queue
// Watches both channels, keeps a shadow copy of the sorted task list, and
// compares every accepted result against the oldest predicted one.
// ----------------------------------------------------------------------------
module sptq_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [sptq_pkg::IdWidth-1:0]  req_task_id,
   input  logic [sptq_pkg::PriWidth-1:0] req_priority_req,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [sptq_pkg::IdWidth-1:0]  rsp_out_id,
   input  logic [sptq_pkg::PriWidth-1:0] rsp_out_priority,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            pending_count
);

   import sptq_pkg::*;

   entry_type task_list[$];
   rsp_type   awaited_rsps[$];
   int        mismatch_total = 0;

   function automatic void queue_rsp(input status_type st, input logic [IdWidth-1:0] id,
                                     input logic [PriWidth-1:0] pri, input logic lst);
      rsp_type r;
      r.status = st;
      r.id     = id;
      r.pri    = pri;
      r.last   = lst;
      awaited_rsps.push_back(r);
   endfunction

   // Shadow list update for one command plus the results it must produce
   function automatic void predict_command(input kind_type k, input logic [IdWidth-1:0] id,
                                           input logic [PriWidth-1:0] pri);
      int        pos;
      int        found;
      entry_type e;
      case (k)
         KIND_INSERT: begin
            if (task_list.size() >= CAPACITY) begin
               queue_rsp(STATUS_FULL, '0, '0, 1'b1);
            end else begin
               pos = 0;
               while (pos < task_list.size() && task_list[pos].pri <= pri) pos++;
               e.id  = id;
               e.pri = pri;
               task_list.insert(pos, e);
               queue_rsp(STATUS_OK, id, pri, 1'b1);
            end
         end
         KIND_DELETE: begin
            if (task_list.size() == 0) begin
               queue_rsp(STATUS_EMPTY, '0, '0, 1'b1);
            end else begin
               found = -1;
               for (int i = 0; i < task_list.size(); i++) begin
                  if (found < 0 && task_list[i].id == id) found = i;
               end
               if (found < 0) begin
                  queue_rsp(STATUS_NOTFOUND, '0, '0, 1'b1);
               end else begin
                  queue_rsp(STATUS_OK, task_list[found].id, task_list[found].pri, 1'b1);
                  task_list.delete(found);
               end
            end
         end
         KIND_POP: begin
            if (task_list.size() == 0) begin
               queue_rsp(STATUS_EMPTY, '0, '0, 1'b1);
            end else begin
               queue_rsp(STATUS_OK, task_list[0].id, task_list[0].pri, 1'b1);
               task_list.delete(0);
            end
         end
         default: begin
            if (task_list.size() == 0) begin
               queue_rsp(STATUS_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < task_list.size(); i++)
                  queue_rsp(STATUS_OK, task_list[i].id, task_list[i].pri,
                            i == task_list.size() - 1);
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         task_list.delete();
         awaited_rsps.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_command(kind_type'(req_kind), req_task_id, req_priority_req);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected result status=%0d id=%h pri=%h last=%b",
                           $time, rsp_status, rsp_out_id, rsp_out_priority, rsp_last);
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_status !== want.status || rsp_out_id !== want.id ||
                   rsp_out_priority !== want.pri || rsp_last !== want.last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"%0t: result mismatch: expected status=%0d id=%h pri=%h ",
                               "last=%b, got status=%0d id=%h pri=%h last=%b"},
                              $time, want.status, want.id, want.pri, want.last,
                              rsp_status, rsp_out_id, rsp_out_priority, rsp_last);
               end
            end
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= awaited_rsps.size();
   end

endmodule

/* bench/tb_sorted_priority_task_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_task_queue: testbench for the sorted priority task queue
// Directed corner commands, then random phases of insert, delete, pop and
// view traffic with bursty sender gaps and a patterned receiver stall.
// ----------------------------------------------------------------------------
module tb_sorted_priority_task_queue;

   import sptq_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles    = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_kind = KIND_INSERT;
   logic [IdWidth-1:0]  req_task_id = '0;
   logic [PriWidth-1:0] req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [IdWidth-1:0]  rsp_out_id;
   logic [PriWidth-1:0] rsp_out_priority;
   logic                rsp_last;
   int                  fail_count;
   int                  pending_count;

   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   mode_left = 0;
   logic stall_next;
   int   burst_left = 0;
   int   idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_priority_task_queue #(.CAPACITY(16)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_last         (rsp_last)
   );

   sptq_checker #(.CAPACITY(16)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Receiver stall: random modes, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HoldCycles;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 1) == 0);
            default: stall_next = ($urandom_range(0, 7) == 0) ? !rsp_stall : rsp_stall;
         endcase
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
         $display("[sorted_priority_task_queue] ERROR");
         $finish;
      end
   end

   // Offer one command and hold it until accepted; gaps come between bursts
   task automatic send_command(input kind_type k, input logic [IdWidth-1:0] id,
                               input logic [PriWidth-1:0] pri);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_task_id      <= id;
      req_priority_req <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 8);
         burst_left = $urandom_range(0, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Mostly a small id pool so deletes find matches; full-range ids toggle all bits
   function automatic logic [IdWidth-1:0] pick_id();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return IdWidth'($urandom_range(0, 11));
      else if (r < 9) return IdWidth'($urandom_range(0, 65535));
      else return ($urandom_range(0, 1) == 0) ? '0 : '1;
   endfunction

   function automatic logic [PriWidth-1:0] pick_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return PriWidth'($urandom_range(0, 3));
      else if (r < 8) return PriWidth'($urandom_range(0, 255));
      else if (r == 8) return '0;
      else return '1;
   endfunction

   initial begin : stimulus
      int       insert_pct[7];
      int       delete_pct[7];
      int       pop_pct[7];
      int       r;
      kind_type k;
      insert_pct = '{70, 30, 60, 15, 50, 40, 75};
      delete_pct = '{10, 30, 15, 40, 20, 25,  5};
      pop_pct    = '{10, 30, 15, 35, 20, 25,  5};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty queue answers
      send_command(KIND_POP, 16'h1111, 8'h11);
      send_command(KIND_DELETE, 16'h2222, 8'h22);
      send_command(KIND_VIEW, 16'h0000, 8'h00);
      // extremes and equal priorities keeping arrival order
      send_command(KIND_INSERT, 16'h0000, 8'h00);
      send_command(KIND_INSERT, 16'hFFFF, 8'hFF);
      send_command(KIND_INSERT, 16'h5A5A, 8'h80);
      send_command(KIND_INSERT, 16'hA5A5, 8'h80);
      send_command(KIND_VIEW, 16'hFFFF, 8'hFF);
      send_command(KIND_DELETE, 16'h7777, 8'h00);
      send_command(KIND_DELETE, 16'hA5A5, 8'h00);
      // duplicate id: delete takes the one nearest the head
      send_command(KIND_INSERT, 16'h5A5A, 8'h00);
      send_command(KIND_DELETE, 16'h5A5A, 8'hFF);
      send_command(KIND_POP, 16'h0000, 8'h00);
      // fill to capacity, then one insert too many and a full view
      for (int i = 0; i < 14; i++)
         send_command(KIND_INSERT, IdWidth'(16'h0100 + i), PriWidth'((i * 37) % 256));
      send_command(KIND_INSERT, 16'hBEEF, 8'h01);
      send_command(KIND_VIEW, 16'h0000, 8'h00);
      wait_all_results();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 2) hold_request <= 1'b1;
         for (int n = 0; n < 40; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct[ph]) k = KIND_INSERT;
            else if (r < insert_pct[ph] + delete_pct[ph]) k = KIND_DELETE;
            else if (r < insert_pct[ph] + delete_pct[ph] + pop_pct[ph]) k = KIND_POP;
            else k = KIND_VIEW;
            send_command(k, pick_id(), pick_priority());
         end
         wait_all_results();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[sorted_priority_task_queue] OK");
      else
         $display("[sorted_priority_task_queue] ERROR");
      $finish;
   end

endmodule
